>>> hw/rtl/bbmp_pkg.sv
// shared widths, limits and control types for the block partition engine
package bbmp_pkg;

   localparam int WEIGHT_W  = 16;
   localparam int IDX_W     = 20;
   localparam int COST_W    = 32;
   localparam int LEN_OUT_W = 5;
   localparam int CFG_W     = 5;

   localparam logic [IDX_W-1:0]  IDX_MAX   = 20'hFFFFF;
   localparam logic [COST_W-1:0] COST_MAX  = 32'hFFFF_FFFF;
   localparam logic [CFG_W-1:0]  CFG_RESET = 5'd4;

   typedef struct packed {
      logic clear;
      logic valid;
      logic take_first;
      logic cost_zero;
   } eval_ctl_type;

endpackage

>>> hw/rtl/bbmp_ifs.sv
// valid/ready channel interfaces for request, response and csr words
interface bbmp_req_if;
   logic                          valid;
   logic                          ready;
   logic [bbmp_pkg::WEIGHT_W-1:0] weight;
   logic                          first_item;

   modport source (output valid, weight, first_item, input ready);
   modport sink   (input valid, weight, first_item, output ready);
endinterface

interface bbmp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bbmp_pkg::IDX_W-1:0]     item_index;
   logic [bbmp_pkg::COST_W-1:0]    best_cost;
   logic [bbmp_pkg::IDX_W-1:0]     last_block_start;
   logic [bbmp_pkg::LEN_OUT_W-1:0] last_block_len;
   logic                           saturated;

   modport source (output valid, item_index, best_cost, last_block_start, last_block_len,
                   saturated, input ready);
   modport sink   (input valid, item_index, best_cost, last_block_start, last_block_len,
                   saturated, output ready);
endinterface

interface bbmp_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bbmp_pkg::CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/bbmp_ram.sv
// generic single-write, single-read ram with registered read data
module bbmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bbmp_eval.sv
// candidate evaluation: running block maximum, saturating sum and best choice
module bbmp_eval #(
   parameter int WS = 16,
   parameter int LW = 5
) (
   input  logic                          clock,
   input  bbmp_pkg::eval_ctl_type        ctl,
   input  logic [LW-1:0]                 cand_len,
   input  logic [WS-1:0]                 weight_rd,
   input  logic [bbmp_pkg::COST_W-1:0]   cost_rd,
   output logic [bbmp_pkg::COST_W-1:0]   best,
   output logic [LW-1:0]                 best_len
);

   logic [WS-1:0]                mx_ff;
   logic [WS-1:0]                mx_in;
   logic [bbmp_pkg::COST_W-1:0]  best_ff;
   logic [LW-1:0]                best_len_ff;
   logic [bbmp_pkg::COST_W-1:0]  base;
   logic [bbmp_pkg::COST_W:0]    sum;
   logic [bbmp_pkg::COST_W-1:0]  cand;
   logic                         take;

   always_comb begin
      mx_in = (weight_rd > mx_ff) ? weight_rd : mx_ff;
      base  = ctl.cost_zero ? '0 : cost_rd;
      sum   = {1'b0, base} + (bbmp_pkg::COST_W + 1)'(mx_in);
      cand  = sum[bbmp_pkg::COST_W] ? bbmp_pkg::COST_MAX : sum[bbmp_pkg::COST_W-1:0];
      take  = ctl.take_first || (cand < best_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mx_ff <= '0;
      end else if (ctl.valid) begin
         mx_ff <= mx_in;
         if (take) begin
            best_ff     <= cand;
            best_len_ff <= cand_len;
         end
      end
   end

   assign best     = best_ff;
   assign best_len = best_len_ff;

endmodule

>>> hw/rtl/bounded_block_max_partition_dp.sv
// top level: bounded-length block partition with minimum sum of block maxima
//
// Each request word carries one item weight; one response word per item gives the
// least total of block maxima so far and the final block of that optimum. The last
// MAX_BLOCK weights and optimal costs sit in two circular rams. Each item is taken
// in steps: accept it and write the weight, then run candidate lengths from one to
// avail, the smaller of the clamped max_block_len and the item's index in its
// sequence, through the ram read ports and the shared add/compare unit, drain the
// last one, and write the cost back and load the response register. A finished
// response waits in its own register, so the next item is taken while it is still
// pending.
module bounded_block_max_partition_dp #(
   parameter int MAX_BLOCK   = 16,
   parameter int WEIGHT_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   bbmp_req_if.sink    req_ch,
   bbmp_rsp_if.source  rsp_ch,
   bbmp_csr_if.sink    csr_ch
);

   localparam int WS = (WEIGHT_BITS < bbmp_pkg::WEIGHT_W) ? WEIGHT_BITS : bbmp_pkg::WEIGHT_W;
   localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int LW = $clog2(MAX_BLOCK + 2);
   localparam int IW = bbmp_pkg::IDX_W;
   localparam int CW = bbmp_pkg::COST_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_BLOCK - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_SLOT : p - 1'b1;
   endfunction

   logic [1:0]                        state_ff, state_in;
   logic [bbmp_pkg::CFG_W-1:0]        cfg_ff;
   logic [IW-1:0]                     idx_ff, idx_in;
   logic                              sat_ff, sat_in;
   logic [AW-1:0]                     head_ff, head_in;
   logic [AW-1:0]                     wptr_ff, wptr_in;
   logic [AW-1:0]                     cptr_ff, cptr_in;
   logic [LW-1:0]                     iss_len_ff, iss_len_in;
   logic [LW-1:0]                     avail_ff, avail_in;
   logic                              proc_valid_ff, proc_valid_in;
   logic [LW-1:0]                     proc_len_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]                     out_idx_ff;
   logic [CW-1:0]                     out_cost_ff;
   logic [IW-1:0]                     out_start_ff;
   logic [bbmp_pkg::LEN_OUT_W-1:0]    out_len_ff;
   logic                              out_sat_ff;

   logic                              req_fire;
   logic                              issue;
   logic                              out_load;
   logic [LW-1:0]                     k_len;
   logic [WS-1:0]                     weight_rd;
   logic [CW-1:0]                     cost_rd;
   logic [CW-1:0]                     best;
   logic [LW-1:0]                     best_len;
   bbmp_pkg::eval_ctl_type            eval_ctl;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign issue        = (state_ff == ST_RUN) && (iss_len_ff <= avail_ff);
   assign out_load     = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      if (cfg_ff == '0) begin
         k_len = LW'(1);
      end else if (int'(cfg_ff) > MAX_BLOCK) begin
         k_len = LW'(MAX_BLOCK);
      end else begin
         k_len = LW'(cfg_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      sat_in        = sat_ff;
      head_in       = head_ff;
      wptr_in       = wptr_ff;
      cptr_in       = cptr_ff;
      iss_len_in    = iss_len_ff;
      avail_in      = avail_ff;
      proc_valid_in = issue;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.first_item) begin
                  idx_in = IW'(1);
                  sat_in = 1'b0;
               end else if (idx_ff != bbmp_pkg::IDX_MAX) begin
                  idx_in = idx_ff + 1'b1;
               end
               head_in    = slot_inc(head_ff);
               wptr_in    = slot_inc(head_ff);
               cptr_in    = head_ff;
               iss_len_in = LW'(1);
               avail_in   = (IW'(k_len) > idx_in) ? idx_in[LW-1:0] : k_len;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               iss_len_in = iss_len_ff + 1'b1;
               wptr_in    = slot_dec(wptr_ff);
               cptr_in    = slot_dec(cptr_ff);
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_load) begin
               sat_in       = sat_ff || (best == bbmp_pkg::COST_MAX)
                              || (idx_ff == bbmp_pkg::IDX_MAX);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_ff        <= bbmp_pkg::CFG_RESET;
         idx_ff        <= '0;
         sat_ff        <= 1'b0;
         head_ff       <= '0;
         proc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         sat_ff        <= sat_in;
         head_ff       <= head_in;
         proc_valid_ff <= proc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            cfg_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      wptr_ff     <= wptr_in;
      cptr_ff     <= cptr_in;
      iss_len_ff  <= iss_len_in;
      avail_ff    <= avail_in;
      proc_len_ff <= iss_len_ff;
      if (out_load) begin
         out_idx_ff   <= idx_ff;
         out_cost_ff  <= best;
         out_start_ff <= idx_ff - IW'(best_len) + IW'(1);
         out_len_ff   <= bbmp_pkg::LEN_OUT_W'(best_len);
         out_sat_ff   <= sat_in;
      end
   end

   bbmp_ram #(.WIDTH(WS), .DEPTH(MAX_BLOCK)) u_weight_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (slot_inc(head_ff)),
      .wr_data (req_ch.weight[WS-1:0]),
      .rd_en   (issue),
      .rd_addr (wptr_ff),
      .rd_data (weight_rd)
   );

   bbmp_ram #(.WIDTH(CW), .DEPTH(MAX_BLOCK)) u_cost_ram (
      .clock   (clock),
      .wr_en   (out_load),
      .wr_addr (head_ff),
      .wr_data (best),
      .rd_en   (issue),
      .rd_addr (cptr_ff),
      .rd_data (cost_rd)
   );

   always_comb begin
      eval_ctl.clear      = req_fire;
      eval_ctl.valid      = proc_valid_ff;
      eval_ctl.take_first = (proc_len_ff == LW'(1));
      eval_ctl.cost_zero  = (idx_ff == IW'(proc_len_ff));
   end

   bbmp_eval #(.WS(WS), .LW(LW)) u_eval (
      .clock     (clock),
      .ctl       (eval_ctl),
      .cand_len  (proc_len_ff),
      .weight_rd (weight_rd),
      .cost_rd   (cost_rd),
      .best      (best),
      .best_len  (best_len)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.item_index       = out_idx_ff;
   assign rsp_ch.best_cost        = out_cost_ff;
   assign rsp_ch.last_block_start = out_start_ff;
   assign rsp_ch.last_block_len   = out_len_ff;
   assign rsp_ch.saturated        = out_sat_ff;

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the bounded block partition engine
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BLK     = 16;
   localparam int SAT_RUN     = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int SEG_WORDS   = 42;
   localparam int N_SEGS      = 9;
   localparam int N_DIRECTED  = 16;

   typedef struct packed {
      logic [bbmp_pkg::IDX_W-1:0]     item_index;
      logic [bbmp_pkg::COST_W-1:0]    best_cost;
      logic [bbmp_pkg::IDX_W-1:0]     block_start;
      logic [bbmp_pkg::LEN_OUT_W-1:0] block_len;
      logic                           saturated;
   } partition_word_type;

   typedef struct packed {
      logic [bbmp_pkg::WEIGHT_W-1:0] weight;
      logic                          first_item;
      logic                          typed;
      partition_word_type            want;
   } stim_row_type;

   // typed rows: the first item after reset and the items that restart a sequence
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      {16'h0000, 1'b0, 1'b1, 20'd1, 32'd0,          20'd1, 5'd1, 1'b0},
      {16'hFFFF, 1'b0, 1'b0, 78'd0},
      {16'h0001, 1'b0, 1'b0, 78'd0},
      {16'hFFFF, 1'b0, 1'b0, 78'd0},
      {16'h0000, 1'b0, 1'b0, 78'd0},
      {16'h8000, 1'b0, 1'b0, 78'd0},
      {16'h7FFF, 1'b0, 1'b0, 78'd0},
      {16'hFFFF, 1'b1, 1'b1, 20'd1, 32'h0000FFFF, 20'd1, 5'd1, 1'b0},
      {16'h5555, 1'b0, 1'b0, 78'd0},
      {16'hAAAA, 1'b0, 1'b0, 78'd0},
      {16'h0001, 1'b1, 1'b1, 20'd1, 32'd1,          20'd1, 5'd1, 1'b0},
      {16'h0001, 1'b0, 1'b0, 78'd0},
      {16'h0009, 1'b0, 1'b0, 78'd0},
      {16'h0002, 1'b0, 1'b0, 78'd0},
      {16'h0008, 1'b0, 1'b0, 78'd0},
      {16'h0003, 1'b0, 1'b0, 78'd0}
   };

   localparam logic [bbmp_pkg::CFG_W-1:0] LIMIT_PLAN [N_SEGS] = '{
      5'd16, 5'd1, 5'd31, 5'd17, 5'd2, 5'd16, 5'd7, 5'd3, 5'd16
   };

   logic clock;
   logic reset;

   bbmp_req_if req_ch();
   bbmp_rsp_if rsp_ch();
   bbmp_csr_if csr_ch();

   bounded_block_max_partition_dp #(
      .MAX_BLOCK   (MAX_BLK),
      .WEIGHT_BITS (bbmp_pkg::WEIGHT_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [bbmp_pkg::WEIGHT_W-1:0] hist_weight [MAX_BLK];
   logic [bbmp_pkg::COST_W-1:0]   hist_cost [MAX_BLK+1];
   logic [bbmp_pkg::IDX_W-1:0]    seq_count;
   logic                          sat_seen;
   logic [bbmp_pkg::CFG_W-1:0]    blk_limit;

   partition_word_type pending_q[$];

   int err_count;
   int words_sent;
   int words_checked;
   int cfg_writes;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   bit hold_go;
   bit hold_armed;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void clear_history();
      for (int j = 0; j < MAX_BLK; j++) hist_weight[j] = '0;
      for (int j = 0; j <= MAX_BLK; j++) hist_cost[j] = '0;
      seq_count = '0;
      sat_seen  = 1'b0;
   endfunction

   function automatic partition_word_type solve_prefix(
         input logic [bbmp_pkg::WEIGHT_W-1:0] w, input logic first_item);
      partition_word_type            res;
      int                            k;
      int                            avail;
      int                            best_len;
      logic [bbmp_pkg::WEIGHT_W-1:0] run_max;
      logic [bbmp_pkg::COST_W:0]     sum;
      logic [bbmp_pkg::COST_W-1:0]   cand;
      logic [bbmp_pkg::COST_W-1:0]   best;
      if (first_item) clear_history();
      if (seq_count != bbmp_pkg::IDX_MAX) seq_count++;
      for (int j = MAX_BLK - 1; j > 0; j--) hist_weight[j] = hist_weight[j-1];
      hist_weight[0] = w;
      k = blk_limit;
      if (k < 1) k = 1;
      if (k > MAX_BLK) k = MAX_BLK;
      avail = (int'(seq_count) < k) ? int'(seq_count) : k;
      run_max  = '0;
      best     = '0;
      best_len = 1;
      for (int n = 1; n <= avail; n++) begin
         if (hist_weight[n-1] > run_max) run_max = hist_weight[n-1];
         sum  = {1'b0, hist_cost[n-1]} + run_max;
         cand = sum[bbmp_pkg::COST_W] ? bbmp_pkg::COST_MAX : sum[bbmp_pkg::COST_W-1:0];
         if (n == 1 || cand < best) begin
            best     = cand;
            best_len = n;
         end
      end
      for (int j = MAX_BLK; j > 0; j--) hist_cost[j] = hist_cost[j-1];
      hist_cost[0] = best;
      if (best == bbmp_pkg::COST_MAX || seq_count == bbmp_pkg::IDX_MAX) sat_seen = 1'b1;
      res.item_index  = seq_count;
      res.best_cost   = best;
      res.block_start = seq_count - bbmp_pkg::IDX_W'(best_len) + 1'b1;
      res.block_len   = bbmp_pkg::LEN_OUT_W'(best_len);
      res.saturated   = sat_seen;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h (response word %0d)",
               $time, field, got, want, words_checked);
      err_count++;
   endtask

   task automatic offer_weight(input logic [bbmp_pkg::WEIGHT_W-1:0] w,
                               input logic first_item, input logic typed,
                               input partition_word_type typed_word);
      partition_word_type pred;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.weight     <= w;
      req_ch.first_item <= first_item;
      do @(posedge clock); while (!req_ch.ready);
      pred = solve_prefix(w, first_item);
      pending_q.insert(pending_q.size(), typed ? typed_word : pred);
      words_sent++;
   endtask

   task automatic wait_results_done();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_block_limit(input logic [bbmp_pkg::CFG_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      blk_limit = value;
      cfg_writes++;
   endtask

   // long receiver hold-off, armed once
   always @(posedge clock) begin
      if (hold_go && !hold_armed) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= (hold_left == 0) &&
                      (recv_idle_pct == 0 || $urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      partition_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.item_index, '0);
         end else begin
            want = pending_q.pop_front();
            words_checked++;
            if (rsp_ch.item_index !== want.item_index)
               report_mismatch("item_index", rsp_ch.item_index, want.item_index);
            if (rsp_ch.best_cost !== want.best_cost)
               report_mismatch("best_cost", rsp_ch.best_cost, want.best_cost);
            if (rsp_ch.last_block_start !== want.block_start)
               report_mismatch("last_block_start", rsp_ch.last_block_start,
                               want.block_start);
            if (rsp_ch.last_block_len !== want.block_len)
               report_mismatch("last_block_len", rsp_ch.last_block_len, want.block_len);
            if (rsp_ch.saturated !== want.saturated)
               report_mismatch("saturated", rsp_ch.saturated, want.saturated);
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [bbmp_pkg::CFG_W-1:0]    limit;
      logic [bbmp_pkg::WEIGHT_W-1:0] w;
      err_count     = 0;
      words_sent    = 0;
      words_checked = 0;
      cfg_writes    = 0;
      send_idle_pct = 18;
      recv_idle_pct = 65;
      clear_history();
      blk_limit = bbmp_pkg::CFG_RESET;
      reset              = 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.weight     <= '0;
      req_ch.first_item <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.data       <= bbmp_pkg::CFG_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         offer_weight(DIRECTED[i].weight, DIRECTED[i].first_item, DIRECTED[i].typed,
                      DIRECTED[i].want);
      wait_results_done();

      // receiver stalls while words keep coming
      hold_go <= 1'b1;
      for (int i = 0; i < 24; i++)
         offer_weight(16'($urandom), i == 0, 1'b0, '0);
      wait_results_done();

      // length register zero with all-ones weights, then random weights
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_block_limit('0);
      for (int i = 0; i < SAT_RUN; i++)
         offer_weight(16'hFFFF, i == 0, 1'b0, '0);
      for (int i = 0; i < 6; i++)
         offer_weight(16'($urandom), 1'b0, 1'b0, '0);
      wait_results_done();

      for (int seg = 0; seg < N_SEGS; seg++) begin
         case (seg / 3)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         limit = (seg == 4 || seg == 6) ? bbmp_pkg::CFG_W'($urandom_range(2, 15))
                                        : LIMIT_PLAN[seg];
         wait_results_done();
         write_block_limit(limit);
         for (int i = 0; i < SEG_WORDS; i++) begin
            case ($urandom_range(3))
               0: w = 16'($urandom);
               1: w = 16'($urandom_range(15));
               2: w = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               default: w = 16'($urandom_range(255));
            endcase
            offer_weight(w, (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(29) == 0),
                         1'b0, '0);
         end
      end

      wait_results_done();
      repeat (30) @(posedge clock);
      $display("covered %0d request words and %0d response words over %0d length settings,",
               words_sent, words_checked, cfg_writes);
      $display("with a zero length setting and a %0d cycle response hold-off", HOLD_CYCLES);
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bbmp_pkg.sv
hw/rtl/bbmp_ifs.sv
hw/rtl/bbmp_ram.sv
hw/rtl/bbmp_eval.sv
hw/rtl/bounded_block_max_partition_dp.sv
tb/sv/tb_top.sv
